// File: rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants for the small matrix arithmetic block: operation
// and action codes, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sma_pkg;

  // Fraction bits of the Q16.16 format
  localparam int unsigned FRAC_BITS = 16;

  // Configuration register indexes (word address)
  localparam logic [1:0] REG_OPERATION = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [1:0] REG_INNER_COUNT = 2'd2;
  localparam logic [1:0] REG_COL_COUNT = 2'd3;

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_NEG   = 3'd3,
    OP_TRANS = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOLD,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic wr_a;       // write first matrix element
    logic wr_b;       // write second matrix element
    logic issue;      // read addresses valid this cycle
    logic first;      // first term of the element
    logic last_k;     // last term of the element
    logic last_elem;  // element under work is the last of the run
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;       // result element goes to the output register now
    logic out_busy;   // output register holds an untaken result
  } status_t;

endpackage

// File: rtl/sma_ram.sv
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sma_ctrl.sv
// ----------------------------------------------------------------------------
// sma_ctrl
// Sequencer: decodes input transactions, walks the result coordinates in
// row-major order and the inner index of each element, and drives the matrix
// read and write addresses.
// ----------------------------------------------------------------------------
module sma_ctrl #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           action_i,
  input  logic [2:0]                           row_index_i,
  input  logic [2:0]                           col_index_i,
  input  logic [2:0]                           op_i,
  input  logic [3:0]                           row_count_i,
  input  logic [3:0]                           inner_count_i,
  input  logic [3:0]                           col_count_i,
  input  sma_pkg::status_t                     status_i,
  output sma_pkg::cmd_t                        cmd_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   waddr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   raddr_a_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   raddr_b_o,
  output logic [$clog2(MAX_DIM)-1:0]           res_row_o,
  output logic [$clog2(MAX_DIM)-1:0]           res_col_o
);

  localparam int unsigned IW = $clog2(MAX_DIM);
  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  sma_pkg::state_e state_q, state_d;
  logic [IW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [IW-1:0] rows_last, inner_last, cols_last;
  logic [IW-1:0] r_last, c_last, k_last;
  logic          in_accept, op_ok, idx_ok, start, run_last;

  // Clamp a count to 1..MAX_DIM and give its last index
  function automatic logic [IW-1:0] last_idx(input logic [3:0] cnt);
    if (cnt == 4'd0) begin
      return '0;
    end else if (cnt > 4'(MAX_DIM)) begin
      return IW'(MAX_DIM - 1);
    end else begin
      return IW'(cnt - 4'd1);
    end
  endfunction

  function automatic logic [AW-1:0] flat(input logic [IW-1:0] row, input logic [IW-1:0] col);
    return AW'(int'(row) * MAX_DIM + int'(col));
  endfunction

  // Decode the transaction and the loop bounds of the configured operation
  always_comb begin
    rows_last  = last_idx(row_count_i);
    inner_last = last_idx(inner_count_i);
    cols_last  = last_idx(col_count_i);
    in_accept  = in_valid_i && in_ready_o;
    op_ok      = op_i <= sma_pkg::OP_TRANS;
    idx_ok     = ({1'b0, row_index_i} < 4'(MAX_DIM)) && ({1'b0, col_index_i} < 4'(MAX_DIM));
    start      = in_accept && (action_i == sma_pkg::ACT_START) && op_ok;
    case (op_i)
      sma_pkg::OP_MUL: begin
        r_last = rows_last;
        c_last = cols_last;
        k_last = inner_last;
      end
      sma_pkg::OP_TRANS: begin
        r_last = inner_last;
        c_last = rows_last;
        k_last = '0;
      end
      default: begin
        r_last = rows_last;
        c_last = inner_last;
        k_last = '0;
      end
    endcase
    run_last = (r_q == r_last) && (c_q == c_last);
  end

  // Next state and loop counters
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    case (state_q)
      sma_pkg::ST_IDLE: begin
        if (start) begin
          state_d = sma_pkg::ST_HOLD;
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
        end
      end
      sma_pkg::ST_HOLD: begin
        if (!status_i.out_busy) begin
          state_d = sma_pkg::ST_ISSUE;
        end
      end
      sma_pkg::ST_ISSUE: begin
        k_d = k_q + 1'b1;
        if (k_q == k_last) begin
          state_d = sma_pkg::ST_WAIT;
        end
      end
      sma_pkg::ST_WAIT: begin
        if (status_i.done) begin
          k_d = '0;
          if (run_last) begin
            state_d = sma_pkg::ST_IDLE;
          end else begin
            state_d = sma_pkg::ST_HOLD;
            if (c_q == c_last) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = sma_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands and addresses
  always_comb begin
    in_ready_o       = state_q == sma_pkg::ST_IDLE;
    cmd_o.wr_a       = in_accept && (action_i == sma_pkg::ACT_LOAD_A) && idx_ok;
    cmd_o.wr_b       = in_accept && (action_i == sma_pkg::ACT_LOAD_B) && idx_ok;
    cmd_o.issue      = state_q == sma_pkg::ST_ISSUE;
    cmd_o.first      = k_q == '0;
    cmd_o.last_k     = k_q == k_last;
    cmd_o.last_elem  = run_last;
    waddr_o          = flat(row_index_i[IW-1:0], col_index_i[IW-1:0]);
    case (op_i)
      sma_pkg::OP_MUL: begin
        raddr_a_o = flat(r_q, k_q);
        raddr_b_o = flat(k_q, c_q);
      end
      sma_pkg::OP_TRANS: begin
        raddr_a_o = flat(c_q, r_q);
        raddr_b_o = flat(c_q, r_q);
      end
      default: begin
        raddr_a_o = flat(r_q, c_q);
        raddr_b_o = flat(r_q, c_q);
      end
    endcase
    res_row_o = r_q;
    res_col_o = c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sma_pkg::ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

endmodule

// File: rtl/sma_datapath.sv
// ----------------------------------------------------------------------------
// sma_datapath
// Matrix storage, one multiply or add unit, a saturating 64-bit accumulator,
// the final shift and clamp, and the output register.
// ----------------------------------------------------------------------------
module sma_datapath #(
  parameter int unsigned MAX_DIM     = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [2:0]                         op_i,
  input  sma_pkg::cmd_t                      cmd_i,
  output sma_pkg::status_t                   status_o,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] waddr_i,
  input  logic [VALUE_WIDTH-1:0]             wdata_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_a_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_b_i,
  input  logic [$clog2(MAX_DIM)-1:0]         res_row_i,
  input  logic [$clog2(MAX_DIM)-1:0]         res_col_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         result_row_o,
  output logic [2:0]                         result_col_o,
  output logic signed [31:0]                 result_value_o,
  output logic                               last_element_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned VW    = VALUE_WIDTH;
  localparam logic signed [63:0] ValHi = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] ValLo = -ValHi - 64'sd1;
  localparam logic signed [63:0] AccMax = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] AccMin = {1'b1, {63{1'b0}}};

  logic [VW-1:0]          rdata_a, rdata_b;
  logic signed [VW-1:0]   a_s, b_s;
  logic signed [2*VW-1:0] mul_p;
  logic signed [VW:0]     add_p, sub_p, neg_p;
  logic signed [63:0]     term_d, term_q, acc_d, acc_q, acc_sum, pre;
  logic                   acc_ovf;
  logic                   v1_q, first1_q, lastk1_q;
  logic                   v2_q, first2_q, lastk2_q;
  logic                   fin_q;
  logic [VW-1:0]          val_d, val_q;
  logic                   out_valid_q;
  logic [2:0]             row_q, col_q;
  logic                   last_q;

  sma_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_a_i),
    .rdata_o (rdata_a)
  );

  sma_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_b_i),
    .rdata_o (rdata_b)
  );

  // Form one term: product, sum, difference, negation or copy
  always_comb begin
    a_s   = $signed(rdata_a);
    b_s   = $signed(rdata_b);
    mul_p = a_s * b_s;
    add_p = a_s + b_s;
    sub_p = a_s - b_s;
    neg_p = -a_s;
    case (op_i)
      sma_pkg::OP_MUL: term_d = 64'(mul_p);
      sma_pkg::OP_ADD: term_d = 64'(add_p);
      sma_pkg::OP_SUB: term_d = 64'(sub_p);
      sma_pkg::OP_NEG: term_d = 64'(neg_p);
      default:         term_d = 64'(a_s);
    endcase
  end

  // Saturating accumulate
  always_comb begin
    acc_sum = acc_q + term_q;
    acc_ovf = (acc_q[63] == term_q[63]) && (acc_sum[63] != acc_q[63]);
    if (first2_q) begin
      acc_d = term_q;
    end else if (acc_ovf) begin
      acc_d = term_q[63] ? AccMin : AccMax;
    end else begin
      acc_d = acc_sum;
    end
  end

  // Drop the fraction of a product sum and clamp to the value range
  always_comb begin
    pre = (op_i == sma_pkg::OP_MUL) ? (acc_q >>> sma_pkg::FRAC_BITS) : acc_q;
    if (pre > ValHi) begin
      val_d = ValHi[VW-1:0];
    end else if (pre < ValLo) begin
      val_d = ValLo[VW-1:0];
    end else begin
      val_d = pre[VW-1:0];
    end
  end

  // Advance the term flags alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      first1_q    <= 1'b0;
      lastk1_q    <= 1'b0;
      v2_q        <= 1'b0;
      first2_q    <= 1'b0;
      lastk2_q    <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q     <= cmd_i.issue;
      first1_q <= cmd_i.first;
      lastk1_q <= cmd_i.last_k;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      lastk2_q <= lastk1_q;
      fin_q    <= v2_q && lastk2_q;
      if (fin_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      term_q <= term_d;
    end
    if (v2_q) begin
      acc_q <= acc_d;
    end
    if (fin_q) begin
      val_q  <= val_d;
      row_q  <= 3'(res_row_i);
      col_q  <= 3'(res_col_i);
      last_q <= cmd_i.last_elem;
    end
  end

  assign status_o.done     = fin_q;
  assign status_o.out_busy = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign result_row_o      = row_q;
  assign result_col_o      = col_q;
  assign result_value_o    = 32'($signed(val_q));
  assign last_element_o    = last_q;

endmodule

// File: rtl/small_matrix_arithmetic.sv
// A load transaction writes its element when it is accepted; one load per cycle
// while the block is idle. A start runs each result element through the HOLD,
// ISSUE and WAIT states, reading one term per inner index for multiply and one
// term otherwise, since each matrix RAM has a single read port and there is one
// multiply-accumulate unit. Reset clears control and the output valid flag and
// resets the configuration; matrix contents are undefined until loaded.
// ----------------------------------------------------------------------------
// small_matrix_arithmetic
// Loads two small Q16.16 matrices element by element and, on start, emits the
// product, sum, difference, negation or transpose row-major with saturation.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic #(
  parameter int unsigned MAX_DIM     = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [2:0]         row_index_i,
  input  logic [2:0]         col_index_i,
  input  logic signed [31:0] element_value_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         result_row_o,
  output logic [2:0]         result_col_o,
  output logic signed [31:0] result_value_o,
  output logic               last_element_o
);

  localparam int unsigned IW = $clog2(MAX_DIM);
  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  logic [2:0]       op_q;
  logic [3:0]       rows_q, inner_q, cols_q;
  logic             cfg_wr;
  sma_pkg::cmd_t    cmd;
  sma_pkg::status_t status;
  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  logic [IW-1:0]    res_row, res_col;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= sma_pkg::OP_MUL;
      rows_q  <= 4'd1;
      inner_q <= 4'd1;
      cols_q  <= 4'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sma_pkg::REG_OPERATION:   op_q    <= pwdata[2:0];
        sma_pkg::REG_ROW_COUNT:   rows_q  <= pwdata[3:0];
        sma_pkg::REG_INNER_COUNT: inner_q <= pwdata[3:0];
        sma_pkg::REG_COL_COUNT:   cols_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (paddr[3:2])
      sma_pkg::REG_OPERATION:   prdata = {29'd0, op_q};
      sma_pkg::REG_ROW_COUNT:   prdata = {28'd0, rows_q};
      sma_pkg::REG_INNER_COUNT: prdata = {28'd0, inner_q};
      sma_pkg::REG_COL_COUNT:   prdata = {28'd0, cols_q};
      default:                  prdata = '0;
    endcase
  end

  sma_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .op_i          (op_q),
    .row_count_i   (rows_q),
    .inner_count_i (inner_q),
    .col_count_i   (cols_q),
    .status_i      (status),
    .cmd_o         (cmd),
    .waddr_o       (waddr),
    .raddr_a_o     (raddr_a),
    .raddr_b_o     (raddr_b),
    .res_row_o     (res_row),
    .res_col_o     (res_col)
  );

  sma_datapath #(.MAX_DIM(MAX_DIM), .VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .waddr_i        (waddr),
    .wdata_i        (element_value_i[VALUE_WIDTH-1:0]),
    .raddr_a_i      (raddr_a),
    .raddr_b_i      (raddr_b),
    .res_row_i      (res_row),
    .res_col_i      (res_col),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_row_o   (result_row_o),
    .result_col_o   (result_col_o),
    .result_value_o (result_value_o),
    .last_element_o (last_element_o)
  );

endmodule

// File: rtl/sma_checker.sv
// ----------------------------------------------------------------------------
// sma_checker
// Port-level checks on the small matrix arithmetic block, bound to the top.
// ----------------------------------------------------------------------------
module sma_checker #(
  parameter int unsigned MAX_DIM = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         result_row_o,
  input logic [2:0]         result_col_o,
  input logic signed [31:0] result_value_o,
  input logic               last_element_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o)
      && $stable(last_element_o))
    else $error("stalled result changed");

  // Result coordinates stay within the matrix
  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_row_o < MAX_DIM) && (result_col_o < MAX_DIM))
    else $error("result coordinate out of range");

  // The block takes new transactions as soon as the final result appears
  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && last_element_o |-> in_ready_o)
    else $error("input blocked behind final result");

  // Mid-run results keep the input closed
  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_element_o |-> !in_ready_o)
    else $error("input open during a run");

  // No transaction yields a result in the next cycle
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared right after a transaction");

endmodule

bind small_matrix_arithmetic sma_checker #(.MAX_DIM(MAX_DIM)) u_sma_checker (.*);

// File: tb/small_matrix_arithmetic_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// small_matrix_arithmetic_tb
// Self-checking bench for the small matrix arithmetic block. Element loads and
// start transactions go in over a valid/ready channel and the operation and
// dimensions are set over the APB port while the block is idle. A behavioral
// predictor keeps its own copy of both matrices and the registers, computes
// every result element at each accepted start, and each output transaction is
// compared field by field against the oldest predicted element. Directed
// corner cases come first, then a backlog phase with a long output stall, then
// random load/start sequences with random gaps on both sides.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic_tb;

  localparam int unsigned DIM          = 8;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned BACKLOG_HOLD = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [1:0] ACT_IGNORED   = 2'd3;
  localparam logic [2:0] OP_UNDEF_LO   = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI   = 3'd7;

  localparam logic [31:0] Q_MIN   = 32'h8000_0000;
  localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
  localparam longint      ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint      ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam longint      VAL_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      VAL_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } element_t;

  typedef struct {
    logic [1:0]  action;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
  } stim_t;

  // Predictor and store of expected result elements
  class matrix_checker;
    logic [2:0]  op_code;
    logic [3:0]  row_cfg;
    logic [3:0]  inner_cfg;
    logic [3:0]  col_cfg;
    logic [31:0] mat_a [DIM][DIM];
    logic [31:0] mat_b [DIM][DIM];
    element_t    pending_elements[$];
    int unsigned mismatches;

    function new();
      op_code    = sma_pkg::OP_MUL;
      row_cfg    = 4'd1;
      inner_cfg  = 4'd1;
      col_cfg    = 4'd1;
      mismatches = 0;
      foreach (mat_a[i, j]) begin
        mat_a[i][j] = '0;
        mat_b[i][j] = '0;
      end
    endfunction

    // Clamp a dimension register to 1..DIM
    function int unsigned span(logic [3:0] count);
      if (count == 4'd0) return 1;
      if (count > DIM) return DIM;
      return 32'(count);
    endfunction

    function logic [31:0] saturate(longint v);
      if (v > VAL_MAX) return Q_MAX;
      if (v < VAL_MIN) return Q_MIN;
      return v[31:0];
    endfunction

    function void emit_element(int unsigned r, int unsigned c, longint v, bit last);
      element_t e;
      e.row   = r[2:0];
      e.col   = c[2:0];
      e.value = saturate(v);
      e.last  = last;
      pending_elements.push_back(e);
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        sma_pkg::REG_OPERATION:   op_code   = data[2:0];
        sma_pkg::REG_ROW_COUNT:   row_cfg   = data[3:0];
        sma_pkg::REG_INNER_COUNT: inner_cfg = data[3:0];
        sma_pkg::REG_COL_COUNT:   col_cfg   = data[3:0];
        default: ;
      endcase
    endfunction

    // Expand one start into its row-major result elements
    function void predict_run();
      int unsigned rows, inner, cols;
      longint acc, prod, a, b, v;
      rows  = span(row_cfg);
      inner = span(inner_cfg);
      cols  = span(col_cfg);
      case (op_code)
        sma_pkg::OP_MUL: begin
          for (int i = 0; i < rows; i++)
            for (int j = 0; j < cols; j++) begin
              acc = 0;
              for (int k = 0; k < inner; k++) begin
                prod = longint'($signed(mat_a[i][k])) * longint'($signed(mat_b[k][j]));
                // saturate the accumulator at the 64-bit limits
                if (prod > 0 && acc > ACC_MAX - prod) acc = ACC_MAX;
                else if (prod < 0 && acc < ACC_MIN - prod) acc = ACC_MIN;
                else acc = acc + prod;
              end
              emit_element(i, j, acc >>> sma_pkg::FRAC_BITS,
                           i == rows - 1 && j == cols - 1);
            end
        end
        sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_NEG: begin
          for (int i = 0; i < rows; i++)
            for (int j = 0; j < inner; j++) begin
              a = longint'($signed(mat_a[i][j]));
              b = longint'($signed(mat_b[i][j]));
              if (op_code == sma_pkg::OP_ADD) v = a + b;
              else if (op_code == sma_pkg::OP_SUB) v = a - b;
              else v = -a;
              emit_element(i, j, v, i == rows - 1 && j == inner - 1);
            end
        end
        sma_pkg::OP_TRANS: begin
          for (int j = 0; j < inner; j++)
            for (int i = 0; i < rows; i++)
              emit_element(j, i, longint'($signed(mat_a[i][j])),
                           j == inner - 1 && i == rows - 1);
        end
        default: ;  // undefined operations produce nothing
      endcase
    endfunction

    function void note_transaction(logic [1:0] action, logic [2:0] r, logic [2:0] c,
                                   logic [31:0] value);
      case (action)
        sma_pkg::ACT_LOAD_A: mat_a[r][c] = value;
        sma_pkg::ACT_LOAD_B: mat_b[r][c] = value;
        sma_pkg::ACT_START:  predict_run();
        default: ;
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    function void check_element(element_t got);
      element_t want;
      if (pending_elements.size() == 0) begin
        report($sformatf("unexpected element r%0d c%0d value %h last %0b",
                         got.row, got.col, got.value, got.last));
        return;
      end
      want = pending_elements.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.value !== want.value || got.last !== want.last)
        report($sformatf("expected r%0d c%0d value %h last %0b, got r%0d c%0d value %h last %0b",
                         want.row, want.col, want.value, want.last,
                         got.row, got.col, got.value, got.last));
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [3:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i        = sma_pkg::ACT_LOAD_A;
  logic [2:0]  row_index_i     = '0;
  logic [2:0]  col_index_i     = '0;
  logic signed [31:0] element_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [2:0]  result_row_o;
  logic [2:0]  result_col_o;
  logic signed [31:0] result_value_o;
  logic        last_element_o;

  matrix_checker board;
  bit          a_loaded [DIM][DIM];
  bit          b_loaded [DIM][DIM];
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;
  int unsigned rx_hold_len = 0;
  int unsigned idle_cycles = 0;

  small_matrix_arithmetic DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly small Q16.16 values so products stay in range, with edges and full noise
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2: return $urandom;
      default: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
    endcase
  endfunction

  // Fill unused register bits with noise now and then
  function automatic logic [31:0] with_noise(logic [31:0] field, int unsigned width);
    logic [31:0] mask;
    mask = (32'd1 << width) - 1;
    if ($urandom_range(0, 3) != 0) return field;
    return ($urandom & ~mask) | (field & mask);
  endfunction

  function automatic logic [3:0] draw_count();
    case ($urandom_range(0, 11))
      0: return 4'd0;
      1: return 4'($urandom_range(8, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // Queue loads for every element a start will read, reloading some at random
  function automatic void need_region(ref stim_t plan[$], input logic [1:0] which,
                                      input int unsigned nrows, input int unsigned ncols);
    bit present;
    for (int r = 0; r < nrows; r++)
      for (int c = 0; c < ncols; c++) begin
        present = (which == sma_pkg::ACT_LOAD_A) ? a_loaded[r][c] : b_loaded[r][c];
        if (!present || $urandom_range(0, 2) == 0)
          plan.push_back(stim_t'{which, 3'(r), 3'(c), random_value()});
      end
  endfunction

  function automatic void plan_loads(ref stim_t plan[$]);
    int unsigned rows, inner, cols, pick;
    stim_t tmp;
    rows  = board.span(board.row_cfg);
    inner = board.span(board.inner_cfg);
    cols  = board.span(board.col_cfg);
    case (board.op_code)
      sma_pkg::OP_MUL: begin
        need_region(plan, sma_pkg::ACT_LOAD_A, rows, inner);
        need_region(plan, sma_pkg::ACT_LOAD_B, inner, cols);
      end
      sma_pkg::OP_ADD, sma_pkg::OP_SUB: begin
        need_region(plan, sma_pkg::ACT_LOAD_A, rows, inner);
        need_region(plan, sma_pkg::ACT_LOAD_B, rows, inner);
      end
      sma_pkg::OP_NEG, sma_pkg::OP_TRANS: need_region(plan, sma_pkg::ACT_LOAD_A, rows, inner);
      default: ;
    endcase
    // stray loads and an ignored action as noise
    repeat ($urandom_range(0, 2))
      plan.push_back(stim_t'{($urandom_range(0, 1) != 0) ? sma_pkg::ACT_LOAD_B
                                                         : sma_pkg::ACT_LOAD_A,
                             3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                             random_value()});
    if ($urandom_range(0, 3) == 0)
      plan.push_back(stim_t'{ACT_IGNORED, 3'($urandom_range(0, 7)),
                             3'($urandom_range(0, 7)), $urandom});
    // shuffle
    for (int i = plan.size() - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = plan[i];
      plan[i] = plan[pick];
      plan[pick] = tmp;
    end
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(logic [1:0] action, logic [2:0] r, logic [2:0] c,
                           logic [31:0] value);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= action;
    row_index_i     <= r;
    col_index_i     <= c;
    element_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_transaction(action, r, c, value);
    if (action == sma_pkg::ACT_LOAD_A) a_loaded[r][c] = 1'b1;
    if (action == sma_pkg::ACT_LOAD_B) b_loaded[r][c] = 1'b1;
  endtask

  // Drop valid, wait for every predicted element, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.pending_elements.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_register(idx, data);
  endtask

  task automatic configure(logic [2:0] op, logic [3:0] rows, logic [3:0] inner,
                           logic [3:0] cols);
    wait_idle();
    apb_write(sma_pkg::REG_OPERATION, 32'(op));
    apb_write(sma_pkg::REG_ROW_COUNT, 32'(rows));
    apb_write(sma_pkg::REG_INNER_COUNT, 32'(inner));
    apb_write(sma_pkg::REG_COL_COUNT, 32'(cols));
  endtask

  // Output side: random stalls, bursts without stalls, and one long hold-off
  initial begin : receiver
    int unsigned stall;
    forever begin
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      if (rx_hold_len > 0) begin
        stall = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Check output transactions and watch for a hung block
  always @(posedge clk_i) begin : monitor
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_element(element_t'{row: result_row_o, col: result_col_o,
                                       value: result_value_o, last: last_element_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_t       plan[$];
    logic [2:0]  op;
    int unsigned stim_count;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Accumulator overflow: three 2^62 products saturate, a negative term follows
    configure(sma_pkg::OP_MUL, 4'd1, 4'd4, 4'd1);
    for (int k = 0; k < 4; k++) send_item(sma_pkg::ACT_LOAD_A, 3'd0, 3'(k), Q_MIN);
    for (int k = 0; k < 3; k++) send_item(sma_pkg::ACT_LOAD_B, 3'(k), 3'd0, Q_MIN);
    send_item(sma_pkg::ACT_LOAD_B, 3'd3, 3'd0, Q_MAX);
    send_item(sma_pkg::ACT_START, 3'd7, 3'd7, Q_MAX);

    // Negate the minimum; zero counts act as one
    configure(sma_pkg::OP_NEG, 4'd0, 4'd0, 4'd0);
    send_item(sma_pkg::ACT_START, 3'd0, 3'd0, 32'h0);

    // Sum of two minimums saturates low
    configure(sma_pkg::OP_ADD, 4'd1, 4'd1, 4'd1);
    send_item(sma_pkg::ACT_START, 3'd0, 3'd0, 32'h0);

    // Minimum minus maximum saturates low
    configure(sma_pkg::OP_SUB, 4'd1, 4'd1, 4'd1);
    send_item(sma_pkg::ACT_LOAD_B, 3'd0, 3'd0, Q_MAX);
    send_item(sma_pkg::ACT_START, 3'd0, 3'd0, 32'h0);

    // Far corner loads and an ignored action
    send_item(sma_pkg::ACT_LOAD_A, 3'd7, 3'd7, Q_MAX);
    send_item(sma_pkg::ACT_LOAD_B, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(ACT_IGNORED, 3'd7, 3'd7, 32'hFFFF_FFFF);

    // Undefined operations emit nothing, oversized counts clamp
    configure(OP_UNDEF_LO, 4'd15, 4'd15, 4'd15);
    send_item(sma_pkg::ACT_START, 3'd0, 3'd0, 32'h0);
    configure(OP_UNDEF_HI, 4'd8, 4'd8, 4'd8);
    send_item(sma_pkg::ACT_START, 3'd0, 3'd0, 32'h0);

    // Transpose a 2x4 block
    configure(sma_pkg::OP_TRANS, 4'd2, 4'd4, 4'd1);
    for (int k = 0; k < 4; k++) send_item(sma_pkg::ACT_LOAD_A, 3'd1, 3'(k), random_value());
    send_item(sma_pkg::ACT_START, 3'd0, 3'd0, 32'h0);

    // Backlog: hold the output off while starts keep coming, so the input stalls
    configure(sma_pkg::OP_MUL, 4'd3, 4'd3, 4'd3);
    plan_loads(plan);
    foreach (plan[i]) send_item(plan[i].action, plan[i].row, plan[i].col, plan[i].value);
    tx_burst = 1'b1;
    rx_hold_len = BACKLOG_HOLD;
    repeat (4) send_item(sma_pkg::ACT_START, 3'd0, 3'd0, 32'h0);
    tx_burst = 1'b0;
    wait_idle();

    // Random load/start sequences, sometimes chained without a register change
    stim_count = 0;
    while (stim_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        wait_idle();
        if ($urandom_range(0, 7) == 0) op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        else op = 3'($urandom_range(sma_pkg::OP_MUL, sma_pkg::OP_TRANS));
        apb_write(sma_pkg::REG_OPERATION, with_noise(32'(op), 3));
        if ($urandom_range(0, 3) != 0)
          apb_write(sma_pkg::REG_ROW_COUNT, with_noise(32'(draw_count()), 4));
        if ($urandom_range(0, 3) != 0)
          apb_write(sma_pkg::REG_INNER_COUNT, with_noise(32'(draw_count()), 4));
        if ($urandom_range(0, 3) != 0)
          apb_write(sma_pkg::REG_COL_COUNT, with_noise(32'(draw_count()), 4));
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      plan.delete();
      plan_loads(plan);
      repeat (($urandom_range(0, 3) == 0) ? 2 : 1)
        plan.push_back(stim_t'{sma_pkg::ACT_START, 3'($urandom_range(0, 7)),
                               3'($urandom_range(0, 7)), $urandom});
      foreach (plan[i]) begin
        send_item(plan[i].action, plan[i].row, plan[i].col, plan[i].value);
        if (plan[i].action != ACT_IGNORED) stim_count++;
      end
    end
    tx_burst = 1'b0;
    wait_idle();

    if (board.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
